FILE: design/slfa_pkg.sv
// ----------------------------------------------------------------------------
// slfa_pkg: shared types and constants for the sorted-list fit allocator
// Block table geometry, transaction payloads, operation and status codes.
// ----------------------------------------------------------------------------
package slfa_pkg;

    localparam int MAX_BLOCKS        = 32;
    localparam int HEADER_BYTES      = 16;
    localparam int POOL_HEADER_BYTES = 32;
    localparam int POOL_LIMIT        = 32768;
    localparam int POOL_RESET        = 4096;

    localparam int AW = $clog2(MAX_BLOCKS);      // table index width
    localparam int CW = $clog2(MAX_BLOCKS + 1);  // block count width

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    localparam logic [1:0] CFG_FIT_MODE   = 2'd0;
    localparam logic [1:0] CFG_POOL_BYTES = 2'd1;

    typedef struct packed {
        logic        operation;
        logic [15:0] request_size;
        logic [15:0] release_address;
    } t_req;

    typedef struct packed {
        logic [15:0] user_address;
        logic [1:0]  status;
    } t_rsp;

    typedef struct packed {
        logic [15:0] start;
        logic [15:0] length;
        logic        used;
    } t_entry;

    // verdict of the compare unit on one table entry
    typedef struct packed {
        logic        take;   // entry becomes the current pick
        logic        stop;   // scan can end here
        logic [15:0] usable; // length minus header
    } t_evl;

endpackage

FILE: design/slfa_table.sv
// ----------------------------------------------------------------------------
// slfa_table: block table storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module slfa_table (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [slfa_pkg::AW-1:0]  i_waddr,
    input  slfa_pkg::t_entry         i_wdata,
    input  logic [slfa_pkg::AW-1:0]  i_raddr,
    output slfa_pkg::t_entry         o_rdata
);

    slfa_pkg::t_entry r_mem [slfa_pkg::MAX_BLOCKS];
    slfa_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/slfa_eval.sv
// ----------------------------------------------------------------------------
// slfa_eval: shared compare unit
// Judges one table entry against the request during a scan.
// ----------------------------------------------------------------------------
module slfa_eval (
    input  slfa_pkg::t_entry i_entry,
    input  logic             i_op,
    input  logic [15:0]      i_req_size,
    input  logic [15:0]      i_rel_addr,
    input  logic [1:0]       i_fit_mode,
    input  logic             i_have,
    input  logic [15:0]      i_pick_use,
    output slfa_pkg::t_evl   o_evl
);

    logic [15:0] usable;
    logic        tiny;
    logic        fits;
    logic        better;
    logic        first_mode;
    logic        addr_hit;

    always_comb begin
        usable   = i_entry.length - 16'(slfa_pkg::HEADER_BYTES);
        tiny     = i_entry.length < 16'(slfa_pkg::HEADER_BYTES);
        fits     = !i_entry.used && !tiny && (usable >= i_req_size);
        addr_hit = i_entry.used &&
                   (({1'b0, i_entry.start} + 17'(slfa_pkg::HEADER_BYTES))
                    == {1'b0, i_rel_addr});
        case (i_fit_mode)
            slfa_pkg::FIT_BEST:  better = usable < i_pick_use;
            slfa_pkg::FIT_WORST: better = usable > i_pick_use;
            default:             better = 1'b0;
        endcase
        first_mode = !(i_fit_mode == slfa_pkg::FIT_BEST ||
                       i_fit_mode == slfa_pkg::FIT_WORST);

        o_evl.usable = usable;
        if (i_op == slfa_pkg::OP_FREE) begin
            o_evl.take = addr_hit;
            o_evl.stop = addr_hit;
        end else begin
            // ties keep the earlier block: strict compare only
            o_evl.take = fits && (!i_have || better);
            o_evl.stop = fits && !i_have && first_mode;
        end
    end

endmodule

FILE: design/sorted_list_fit_allocator_top.sv
// ----------------------------------------------------------------------------
// sorted_list_fit_allocator_top: heap allocator over an address-ordered table
// Allocate by first, best or worst fit with splitting; free with forward merge.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_req and raise start; the transaction is taken on
//   an edge with start high and busy low. busy stays high until the result.
//   Result channel: o_valid is high for one cycle with o_rsp; the receiver
//   cannot stall it, so it must sample that cycle.
//   Config: i_cfg_we with i_cfg_index / i_cfg_data, only while busy is low.
//   Index 0 is the fit mode, index 1 the pool size (reinitializes the table).
// Sequence, with N blocks in the table and the sequencer doing one table read
// and one table write per cycle (the table has one read and one write port):
//   allocate: scan of k entries (k <= N) and a plan step; a miss ends there,
//             otherwise the pick is marked used, after the tail is moved up
//             and the remainder block written if the block is split.
//   free:     scan of k entries; unless the hit is the last entry, the next
//             entry is read and, if free, merged in with the tail moved down.
//   The result is registered onto o_valid and o_rsp; one transaction at a time.
// Reset: table holds one free block of 4096 bytes at the pool header offset,
// fit mode first fit. No clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_list_fit_allocator_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  slfa_pkg::t_req      i_req,
    output logic                o_valid,
    output slfa_pkg::t_rsp      o_rsp,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data
);

    localparam int AW = slfa_pkg::AW;
    localparam int CW = slfa_pkg::CW;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_PLAN, S_SHUP, S_SPLIT, S_AFIN, S_FRDN, S_FNXT, S_SHDN
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_fit, n_fit;
    logic [15:0]      r_pool, n_pool;
    logic [CW-1:0]    r_count, n_count;
    logic             r_fresh, n_fresh;
    logic             r_rd0;
    logic             r_valid, n_valid;
    slfa_pkg::t_rsp   r_rsp, n_rsp;
    logic             r_have, n_have;

    // payload registers
    logic             r_op, n_op;
    logic [15:0]      r_reqsz, n_reqsz;
    logic [15:0]      r_addr, n_addr;
    logic [AW-1:0]    r_chk, n_chk;
    logic [AW-1:0]    r_pidx, n_pidx;
    logic [15:0]      r_pstart, n_pstart;
    logic [15:0]      r_plen, n_plen;
    logic [15:0]      r_puse, n_puse;
    logic [15:0]      r_need, n_need;
    logic [15:0]      r_rest, n_rest;
    logic             r_split, n_split;
    logic [AW-1:0]    r_src, n_src;

    logic             we;
    logic [AW-1:0]    waddr;
    slfa_pkg::t_entry wdata;
    logic [AW-1:0]    raddr;
    slfa_pkg::t_entry ram_q;
    slfa_pkg::t_entry rd_entry;
    slfa_pkg::t_evl   evl;
    logic             last;
    logic [16:0]      pool_in;

    slfa_table u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    // entry 0 reads as the pool block until first written after init
    always_comb begin
        if (r_rd0 && r_fresh) begin
            rd_entry.start  = 16'(slfa_pkg::POOL_HEADER_BYTES);
            rd_entry.length = r_pool;
            rd_entry.used   = 1'b0;
        end else begin
            rd_entry = ram_q;
        end
    end

    slfa_eval u_eval (
        .i_entry    (rd_entry),
        .i_op       (r_op),
        .i_req_size (r_reqsz),
        .i_rel_addr (r_addr),
        .i_fit_mode (r_fit),
        .i_have     (r_have),
        .i_pick_use (r_puse),
        .o_evl      (evl)
    );

    assign last    = (CW'(r_chk) + CW'(1)) == r_count;
    assign pool_in = {1'b0, i_cfg_data};

    always_comb begin
        n_state  = r_state;
        n_fit    = r_fit;
        n_pool   = r_pool;
        n_count  = r_count;
        n_fresh  = r_fresh;
        n_valid  = 1'b0;
        n_rsp    = r_rsp;
        n_have   = r_have;
        n_op     = r_op;
        n_reqsz  = r_reqsz;
        n_addr   = r_addr;
        n_chk    = r_chk;
        n_pidx   = r_pidx;
        n_pstart = r_pstart;
        n_plen   = r_plen;
        n_puse   = r_puse;
        n_need   = r_need;
        n_rest   = r_rest;
        n_split  = r_split;
        n_src    = r_src;
        we       = 1'b0;
        waddr    = r_pidx;
        wdata    = rd_entry;
        raddr    = '0;

        if (i_cfg_we) begin
            case (i_cfg_index)
                slfa_pkg::CFG_FIT_MODE: n_fit = i_cfg_data[1:0];
                slfa_pkg::CFG_POOL_BYTES: begin
                    n_pool  = (pool_in > 17'(slfa_pkg::POOL_LIMIT)) ?
                              16'(slfa_pkg::POOL_LIMIT) : i_cfg_data;
                    n_fresh = 1'b1;
                    n_count = CW'(1);
                end
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_op    = i_req.operation;
                    n_reqsz = i_req.request_size;
                    n_addr  = i_req.release_address;
                    n_have  = 1'b0;
                    n_chk   = '0;
                    raddr   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (evl.take) begin
                    n_have   = 1'b1;
                    n_pidx   = r_chk;
                    n_pstart = rd_entry.start;
                    n_plen   = rd_entry.length;
                    n_puse   = evl.usable;
                end
                if (r_op == slfa_pkg::OP_FREE) begin
                    if (evl.take) begin
                        n_state = S_FRDN;
                    end else if (last) begin
                        n_valid = 1'b1;
                        n_rsp   = '{user_address: 16'd0, status: slfa_pkg::ST_BADADDR};
                        n_state = S_IDLE;
                    end else begin
                        raddr = r_chk + AW'(1);
                        n_chk = r_chk + AW'(1);
                    end
                end else begin
                    if (evl.stop || last) begin
                        n_state = S_PLAN;
                    end else begin
                        raddr = r_chk + AW'(1);
                        n_chk = r_chk + AW'(1);
                    end
                end
            end
            S_PLAN: begin
                n_need  = r_reqsz + 16'(slfa_pkg::HEADER_BYTES);
                n_rest  = r_plen - n_need;
                n_split = (n_rest > 16'(slfa_pkg::HEADER_BYTES)) &&
                          (r_count < CW'(slfa_pkg::MAX_BLOCKS));
                if (!r_have) begin
                    n_valid = 1'b1;
                    n_rsp   = '{user_address: 16'd0, status: slfa_pkg::ST_NOFIT};
                    n_state = S_IDLE;
                end else if (n_split) begin
                    if ((CW'(r_pidx) + CW'(1)) < r_count) begin
                        // open a slot by moving the tail up, last entry first
                        raddr   = AW'(r_count - CW'(1));
                        n_src   = AW'(r_count - CW'(1));
                        n_state = S_SHUP;
                    end else begin
                        n_state = S_SPLIT;
                    end
                end else begin
                    n_state = S_AFIN;
                end
            end
            S_SHUP: begin
                we    = 1'b1;
                waddr = r_src + AW'(1);
                wdata = rd_entry;
                if (r_src > (r_pidx + AW'(1))) begin
                    raddr = r_src - AW'(1);
                    n_src = r_src - AW'(1);
                end else begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                we      = 1'b1;
                waddr   = r_pidx + AW'(1);
                wdata   = '{start: r_pstart + r_need, length: r_rest, used: 1'b0};
                n_count = r_count + CW'(1);
                n_state = S_AFIN;
            end
            S_AFIN: begin
                we      = 1'b1;
                waddr   = r_pidx;
                wdata   = '{start: r_pstart, length: (r_split ? r_need : r_plen),
                            used: 1'b1};
                n_valid = 1'b1;
                n_rsp   = '{user_address: r_pstart + 16'(slfa_pkg::HEADER_BYTES),
                            status: slfa_pkg::ST_OK};
                n_state = S_IDLE;
            end
            S_FRDN: begin
                if ((CW'(r_pidx) + CW'(1)) < r_count) begin
                    raddr   = r_pidx + AW'(1);
                    n_state = S_FNXT;
                end else begin
                    we      = 1'b1;
                    waddr   = r_pidx;
                    wdata   = '{start: r_pstart, length: r_plen, used: 1'b0};
                    n_valid = 1'b1;
                    n_rsp   = '{user_address: 16'd0, status: slfa_pkg::ST_OK};
                    n_state = S_IDLE;
                end
            end
            S_FNXT: begin
                we    = 1'b1;
                waddr = r_pidx;
                if (!rd_entry.used) begin
                    wdata = '{start: r_pstart, length: r_plen + rd_entry.length,
                              used: 1'b0};
                    if ((CW'(r_pidx) + CW'(2)) < r_count) begin
                        // close the gap: move the tail down one entry at a time
                        raddr   = r_pidx + AW'(2);
                        n_src   = r_pidx + AW'(2);
                        n_state = S_SHDN;
                    end else begin
                        n_count = r_count - CW'(1);
                        n_valid = 1'b1;
                        n_rsp   = '{user_address: 16'd0, status: slfa_pkg::ST_OK};
                        n_state = S_IDLE;
                    end
                end else begin
                    wdata   = '{start: r_pstart, length: r_plen, used: 1'b0};
                    n_valid = 1'b1;
                    n_rsp   = '{user_address: 16'd0, status: slfa_pkg::ST_OK};
                    n_state = S_IDLE;
                end
            end
            S_SHDN: begin
                we    = 1'b1;
                waddr = r_src - AW'(1);
                wdata = rd_entry;
                if ((CW'(r_src) + CW'(1)) < r_count) begin
                    raddr = r_src + AW'(1);
                    n_src = r_src + AW'(1);
                end else begin
                    n_count = r_count - CW'(1);
                    n_valid = 1'b1;
                    n_rsp   = '{user_address: 16'd0, status: slfa_pkg::ST_OK};
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (we && (waddr == '0)) begin
            n_fresh = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fit   <= slfa_pkg::FIT_FIRST;
            r_pool  <= 16'(slfa_pkg::POOL_RESET);
            r_count <= CW'(1);
            r_fresh <= 1'b1;
            r_valid <= 1'b0;
            r_rsp   <= '0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fit   <= n_fit;
            r_pool  <= n_pool;
            r_count <= n_count;
            r_fresh <= n_fresh;
            r_valid <= n_valid;
            r_rsp   <= n_rsp;
            r_have  <= n_have;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd0    <= (raddr == '0);
        r_op     <= n_op;
        r_reqsz  <= n_reqsz;
        r_addr   <= n_addr;
        r_chk    <= n_chk;
        r_pidx   <= n_pidx;
        r_pstart <= n_pstart;
        r_plen   <= n_plen;
        r_puse   <= n_puse;
        r_need   <= n_need;
        r_rest   <= n_rest;
        r_split  <= n_split;
        r_src    <= n_src;
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= CW'(slfa_pkg::MAX_BLOCKS)))
        else $error("block count out of range");

    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (r_count < CW'(slfa_pkg::MAX_BLOCKS)))
        else $error("split with full table");

    a_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_rsp.status != slfa_pkg::ST_OK)) |-> (o_rsp.user_address == 16'd0))
        else $error("failed transaction carries an address");

    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid))
        else $error("accepted command did not start the sequencer");

endmodule
